### src/linear_interp_resampler_assert.svh
// assertion macros for the resampler
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH

`ifndef ASSERT_OFF
`define LIRS_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LIRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define LIRS_ASSERT(label, clk, rst_n, cond, msg)
`define LIRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/lirs_pkg.sv
package lirs_pkg;

    localparam int MAX_CHANNELS = 6;
    localparam int MAX_RUN      = 4;
    localparam int RUN_CNT_W    = 3;
    localparam int GAIN_BITS    = 16;
    localparam int GAIN_SHIFT   = 15;
    localparam int CHAN_BITS    = 3;

    localparam logic [CHAN_BITS-1:0] CHAN_RESET = 3'd2;
    localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 16'h8000;

    localparam logic [1:0] CFG_STEP     = 2'd0;
    localparam logic [1:0] CFG_CHANNELS = 2'd1;
    localparam logic [1:0] CFG_GAIN     = 2'd2;

    localparam logic MODE_SCALE  = 1'b0;
    localparam logic MODE_INTERP = 1'b1;

    typedef struct packed {
        logic mode;
        logic prod_en;
        logic cur_en;
        logic prev_en;
    } t_lane_ctl;

endpackage

### src/lirs_lane.sv
module lirs_lane
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  logic                          i_active,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic        [GAIN_BITS-1:0]   i_gain,
    input  logic        [FRAC_BITS-1:0]   i_frac,
    output logic signed [SAMPLE_BITS-1:0] o_scaled,
    output logic signed [SAMPLE_BITS-1:0] o_interp
);

    localparam int A_W   = SAMPLE_BITS + 1;
    localparam int B_W   = (FRAC_BITS > GAIN_BITS) ? FRAC_BITS + 1 : GAIN_BITS + 1;
    localparam int P_W   = A_W + B_W;
    localparam int ACC_W = P_W + 1;

    localparam logic signed [ACC_W-1:0] SCALE_BIAS = ACC_W'(1) << (GAIN_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_cur;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic signed [P_W-1:0]         r_prod;

    logic signed [A_W-1:0]         w_a;
    logic signed [B_W-1:0]         w_b;
    logic signed [P_W-1:0]         n_prod;
    logic signed [ACC_W-1:0]       w_sc_acc;
    logic signed [ACC_W-1:0]       w_ip_acc;
    logic signed [SAMPLE_BITS-1:0] w_sc_sat;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[SAMPLE_BITS-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    // one shared multiplier: gain scaling, then (cur - prev) * frac
    always_comb begin
        if (i_ctl.mode == MODE_SCALE) begin
            w_a = {i_sample[SAMPLE_BITS-1], i_sample};
            w_b = {{(B_W - GAIN_BITS){1'b0}}, i_gain};
        end else begin
            w_a = {r_cur[SAMPLE_BITS-1], r_cur} - {r_prev[SAMPLE_BITS-1], r_prev};
            w_b = {{(B_W - FRAC_BITS){1'b0}}, i_frac};
        end
    end

    assign n_prod = w_a * w_b;

    // rounding bias folded into the low bits of prev * one
    assign w_sc_acc = ($signed({r_prod[P_W-1], r_prod}) + SCALE_BIAS) >>> GAIN_SHIFT;
    assign w_ip_acc = ($signed({{(ACC_W - FRAC_BITS - SAMPLE_BITS){r_prev[SAMPLE_BITS-1]}},
                                r_prev, 1'b1, {(FRAC_BITS - 1){1'b0}}})
                       + $signed({r_prod[P_W-1], r_prod})) >>> FRAC_BITS;

    assign w_sc_sat = i_active ? sat_smp(w_sc_acc) : '0;
    assign o_scaled = w_sc_sat;
    assign o_interp = sat_smp(w_ip_acc);

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod <= n_prod;
        end
        if (i_ctl.cur_en) begin
            r_cur <= w_sc_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_ctl.prev_en) begin
            r_prev <= r_cur;
        end
    end

endmodule

### src/lirs_merge.sv
module lirs_merge
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_bypass,
    input  logic                          i_last,
    input  logic signed [SAMPLE_BITS-1:0] i_scaled [MAX_CHANNELS],
    input  logic signed [SAMPLE_BITS-1:0] i_interp [MAX_CHANNELS],
    input  logic                          i_out_ready,
    output logic                          o_free,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_data   [MAX_CHANNELS],
    output logic                          o_last
);

    logic                          r_valid;
    logic                          r_last;
    logic signed [SAMPLE_BITS-1:0] r_data [MAX_CHANNELS];

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_last      = r_last;
    assign o_data      = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_last <= i_last;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_data[c] <= i_bypass ? i_scaled[c] : i_interp[c];
            end
        end
    end

endmodule

### src/linear_interp_resampler.sv
// o_out_valid is registered; bypass pushes from S_SCALE, interpolation from S_RES after S_MUL
// frames are accepted only in S_IDLE, after the last one is through; each yields n = 0..4
//   interpolated results or one bypass; one lane multiplier serves scaling and interpolation
// a full output register stalls the run until the transaction is taken
// reset (synchronous, active low): step 1.0, two channels, unity gain, history and phase clear
`include "linear_interp_resampler_assert.svh"

module linear_interp_resampler
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_addr,
    input  logic [((FRAC_BITS + 3 > GAIN_BITS) ? FRAC_BITS + 3 : GAIN_BITS) - 1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch0,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch1,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch2,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch3,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch4,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch5,
    input  logic                          i_block_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_ch0,
    output logic signed [SAMPLE_BITS-1:0] o_out_ch1,
    output logic signed [SAMPLE_BITS-1:0] o_out_ch2,
    output logic signed [SAMPLE_BITS-1:0] o_out_ch3,
    output logic signed [SAMPLE_BITS-1:0] o_out_ch4,
    output logic signed [SAMPLE_BITS-1:0] o_out_ch5,
    output logic                          o_last_of_run
);

    localparam int PH_W = FRAC_BITS + 3;

    localparam logic [PH_W-1:0] PHASE_ONE   = {3'b001, {FRAC_BITS{1'b0}}};
    localparam logic [PH_W-1:0] PHASE_LIMIT = {3'b101, {FRAC_BITS{1'b0}}};
    localparam logic [PH_W-1:0] FRAC_MASK   = {3'b000, {FRAC_BITS{1'b1}}};
    localparam logic [PH_W-1:0] STEP_MIN    = {5'b00001, {(FRAC_BITS - 2){1'b0}}};
    localparam logic [PH_W-1:0] STEP_MAX    = {1'b1, {(FRAC_BITS + 2){1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_RES   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [PH_W-1:0]      r_step;
    logic [CHAN_BITS-1:0] r_chan;
    logic [GAIN_BITS-1:0] r_gain;

    logic [2:0]           r_state;
    logic [PH_W-1:0]      r_phase;
    logic                 r_inside;
    logic                 r_end;
    logic                 r_bypass;
    logic [PH_W-1:0]      r_st;
    logic [RUN_CNT_W-1:0] r_cnt;

    logic [2:0]           n_state;
    logic [PH_W-1:0]      n_phase;
    logic                 n_inside;
    logic [RUN_CNT_W-1:0] n_cnt;

    t_lane_ctl            w_ctl;
    logic                 w_accept;
    logic                 w_push;
    logic                 w_push_bypass;
    logic                 w_push_last;
    logic                 w_out_free;
    logic                 w_run_last;
    logic [PH_W-1:0]      w_phase_add;
    logic [PH_W-1:0]      w_phase_fin;
    logic [PH_W-1:0]      w_eff_step;
    logic [CHAN_BITS-1:0] w_chan_eff;
    logic [RUN_CNT_W-1:0] w_cnt_inc;

    logic signed [SAMPLE_BITS-1:0] w_sample [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] w_scaled [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] w_interp [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] w_data   [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]       w_active;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= PHASE_ONE;
            r_chan <= CHAN_RESET;
            r_gain <= GAIN_UNITY;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_STEP:     r_step <= i_cfg_data[PH_W-1:0];
                CFG_CHANNELS: r_chan <= i_cfg_data[CHAN_BITS-1:0];
                CFG_GAIN:     r_gain <= i_cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_eff_step = (r_step < STEP_MIN) ? STEP_MIN :
                        (r_step > STEP_MAX) ? STEP_MAX : r_step;
    assign w_chan_eff = (r_chan > CHAN_BITS'(MAX_CHANNELS)) ? CHAN_BITS'(MAX_CHANNELS) : r_chan;

    assign w_sample[0] = i_sample_ch0;
    assign w_sample[1] = i_sample_ch1;
    assign w_sample[2] = i_sample_ch2;
    assign w_sample[3] = i_sample_ch3;
    assign w_sample[4] = i_sample_ch4;
    assign w_sample[5] = i_sample_ch5;

    // sequencer
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_phase_add = r_phase + r_st;
    assign w_cnt_inc   = r_cnt + RUN_CNT_W'(1);
    assign w_run_last  = !((w_phase_add < PHASE_ONE) && (w_cnt_inc < RUN_CNT_W'(MAX_RUN)));

    always_comb begin
        w_phase_fin = r_phase;
        if (!r_bypass && r_inside && (r_phase >= PHASE_ONE)) begin
            w_phase_fin = r_phase - PHASE_ONE;
        end
        if (r_end) begin
            w_phase_fin = w_phase_fin & FRAC_MASK;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_inside      = r_inside;
        n_cnt         = r_cnt;
        w_ctl         = '0;
        w_ctl.mode    = MODE_SCALE;
        w_push        = 1'b0;
        w_push_bypass = 1'b0;
        w_push_last   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctl.prod_en = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_SCALE;
                end
            end
            S_SCALE: begin
                w_ctl.cur_en = 1'b1;
                if (r_bypass) begin
                    if (w_out_free) begin
                        w_push        = 1'b1;
                        w_push_bypass = 1'b1;
                        w_push_last   = 1'b1;
                        n_state       = S_FIN;
                    end
                end else if (r_inside && (r_phase < PHASE_ONE)) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MUL: begin
                w_ctl.mode    = MODE_INTERP;
                w_ctl.prod_en = 1'b1;
                n_state       = S_RES;
            end
            S_RES: begin
                w_ctl.mode = MODE_INTERP;
                if (w_out_free) begin
                    w_push      = 1'b1;
                    w_push_last = w_run_last;
                    n_phase     = w_phase_add;
                    n_cnt       = w_cnt_inc;
                    n_state     = w_run_last ? S_FIN : S_MUL;
                end
            end
            S_FIN: begin
                w_ctl.prev_en = 1'b1;
                n_phase       = w_phase_fin;
                n_inside      = !r_end;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= '0;
            r_inside <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_inside <= n_inside;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_end    <= i_block_end;
            r_st     <= w_eff_step;
            r_bypass <= (w_eff_step == PHASE_ONE);
        end
    end

    // channel lanes
    for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
        assign w_active[g] = (w_chan_eff > CHAN_BITS'(g));

        lirs_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .FRAC_BITS   (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_active (w_active[g]),
            .i_sample (w_sample[g]),
            .i_gain   (r_gain),
            .i_frac   (r_phase[FRAC_BITS-1:0]),
            .o_scaled (w_scaled[g]),
            .o_interp (w_interp[g])
        );
    end

    lirs_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_bypass    (w_push_bypass),
        .i_last      (w_push_last),
        .i_scaled    (w_scaled),
        .i_interp    (w_interp),
        .i_out_ready (i_out_ready),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .o_data      (w_data),
        .o_last      (o_last_of_run)
    );

    assign o_out_ch0 = w_data[0];
    assign o_out_ch1 = w_data[1];
    assign o_out_ch2 = w_data[2];
    assign o_out_ch3 = w_data[3];
    assign o_out_ch4 = w_data[4];
    assign o_out_ch5 = w_data[5];

    `LIRS_ASSERT(a_phase_bound, i_clk, i_rst_n, r_phase < PHASE_LIMIT, "phase out of range")
    `LIRS_ASSERT(a_run_bound, i_clk, i_rst_n, r_cnt <= RUN_CNT_W'(MAX_RUN), "run too long")
    `LIRS_ASSERT_IMP(a_push_room, i_clk, i_rst_n, w_push, !o_out_valid || i_out_ready, "push into full output")
    `LIRS_ASSERT_IMP(a_bypass_last, i_clk, i_rst_n, w_push && r_bypass, w_push_last, "bypass result not last")

endmodule

### verif/tb_linear_interp_resampler.sv
`timescale 1ns / 1ps

module tb_linear_interp_resampler;
    import lirs_pkg::*;

    localparam int SMP_W       = 24;
    localparam int FRAC_W      = 16;
    localparam int CFG_W       = (FRAC_W + 3 > GAIN_BITS) ? FRAC_W + 3 : GAIN_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 24;

    localparam logic [FRAC_W+2:0] PHASE_ONE = 19'd65536;
    localparam logic [FRAC_W+2:0] STEP_MIN  = 19'd16384;
    localparam logic [FRAC_W+2:0] STEP_MAX  = 19'd262144;
    localparam longint SMP_HI = 64'sd8388607;
    localparam longint SMP_LO = -64'sd8388608;

    typedef struct packed {
        logic [MAX_CHANNELS-1:0][SMP_W-1:0] smp;
        logic                               eob;
    } audio_frame_t;

    typedef struct packed {
        logic [MAX_CHANNELS-1:0][SMP_W-1:0] ch;
        logic                               last;
    } resampled_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_addr = CFG_STEP;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             o_in_ready;
    logic [SMP_W-1:0] drv_smp [MAX_CHANNELS] = '{default: '0};
    logic             drv_eob = 1'b0;
    logic             o_out_valid;
    logic             out_ready = 1'b0;
    logic [SMP_W-1:0] dut_ch [MAX_CHANNELS];
    logic             o_last_of_run;

    audio_frame_t pending_frames [$];
    resampled_t   expected_out [$];
    audio_frame_t drv_frame;
    int           burst_left = 0;
    int           gap_left = 0;
    int           mismatch_cnt = 0;
    int           cycle_cnt = 0;
    logic [15:0]  ready_pat = 16'hFFFF;
    int           pat_age = 0;

    // resampler state as the block should hold it
    logic [FRAC_W+2:0]   step_reg = PHASE_ONE;
    logic [CHAN_BITS-1:0] chan_reg = CHAN_RESET;
    logic [GAIN_BITS-1:0] gain_reg = GAIN_UNITY;
    longint              hist [MAX_CHANNELS] = '{default: 0};
    logic [FRAC_W+2:0]   phase = '0;
    bit                  in_block = 1'b0;

    linear_interp_resampler u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_ch0 (drv_smp[0]),
        .i_sample_ch1 (drv_smp[1]),
        .i_sample_ch2 (drv_smp[2]),
        .i_sample_ch3 (drv_smp[3]),
        .i_sample_ch4 (drv_smp[4]),
        .i_sample_ch5 (drv_smp[5]),
        .i_block_end  (drv_eob),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_ch0    (dut_ch[0]),
        .o_out_ch1    (dut_ch[1]),
        .o_out_ch2    (dut_ch[2]),
        .o_out_ch3    (dut_ch[3]),
        .o_out_ch4    (dut_ch[4]),
        .o_out_ch5    (dut_ch[5]),
        .o_last_of_run(o_last_of_run)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [SMP_W-1:0] round_sat(longint v, int sh);
        longint t;
        t = (v + (longint'(1) <<< (sh - 1))) >>> sh;
        if (t > SMP_HI)
            t = SMP_HI;
        else if (t < SMP_LO)
            t = SMP_LO;
        return t[SMP_W-1:0];
    endfunction

    function automatic void resample_frame(audio_frame_t f);
        longint            cur [MAX_CHANNELS];
        int                active;
        logic [FRAC_W+2:0] st;
        int                n;
        resampled_t        r;
        resampled_t        run [$];
        longint            acc;

        active = (chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_reg);
        st = (step_reg < STEP_MIN) ? STEP_MIN : (step_reg > STEP_MAX) ? STEP_MAX : step_reg;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            if (c < active)
                cur[c] = longint'($signed(round_sat(
                    longint'($signed(f.smp[c])) * longint'(gain_reg), GAIN_SHIFT)));
            else
                cur[c] = 0;
        end

        if (st == PHASE_ONE) begin
            for (int c = 0; c < MAX_CHANNELS; c++)
                r.ch[c] = cur[c][SMP_W-1:0];
            r.last = 1'b1;
            expected_out.push_back(r);
        end else if (in_block) begin
            n = 0;
            while (phase < PHASE_ONE && n < MAX_RUN) begin
                for (int c = 0; c < MAX_CHANNELS; c++) begin
                    acc = hist[c] * longint'(PHASE_ONE - phase) + cur[c] * longint'(phase);
                    r.ch[c] = round_sat(acc, FRAC_W);
                end
                r.last = 1'b0;
                run.push_back(r);
                phase = phase + st;
                n++;
            end
            if (n > 0)
                run[n-1].last = 1'b1;
            foreach (run[i])
                expected_out.push_back(run[i]);
            if (phase >= PHASE_ONE)
                phase = phase - PHASE_ONE;
        end

        for (int c = 0; c < MAX_CHANNELS; c++)
            hist[c] = cur[c];
        if (f.eob) begin
            phase = {3'b000, phase[FRAC_W-1:0]};
            in_block = 1'b0;
        end else begin
            in_block = 1'b1;
        end
    endfunction

    function automatic audio_frame_t uniform_frame(logic [SMP_W-1:0] v, bit eob);
        audio_frame_t f;
        for (int c = 0; c < MAX_CHANNELS; c++)
            f.smp[c] = v;
        f.eob = eob;
        return f;
    endfunction

    function automatic audio_frame_t random_frame(bit eob);
        audio_frame_t f;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            case ($urandom_range(0, 9))
                0: f.smp[c] = 24'h7FFFFF;
                1: f.smp[c] = 24'h800000;
                2: f.smp[c] = ($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF;
                default: f.smp[c] = SMP_W'($urandom());
            endcase
        end
        f.eob = eob;
        return f;
    endfunction

    task automatic write_reg(logic [1:0] addr, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        case (addr)
            CFG_STEP:     step_reg = data[FRAC_W+2:0];
            CFG_CHANNELS: chan_reg = data[CHAN_BITS-1:0];
            CFG_GAIN:     gain_reg = data[GAIN_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_W-1:0] st, logic [CFG_W-1:0] ch,
                              logic [CFG_W-1:0] g);
        write_reg(CFG_STEP, st);
        write_reg(CFG_CHANNELS, ch);
        write_reg(CFG_GAIN, g);
    endtask

    // block idle: every frame taken, every result seen, pipeline drained
    task automatic drain();
        while (pending_frames.size() > 0 || in_valid || expected_out.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                resample_frame(drv_frame);
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_frames.size() > 0) begin
                    drv_frame = pending_frames.pop_front();
                    for (int c = 0; c < MAX_CHANNELS; c++)
                        drv_smp[c] <= drv_frame.smp[c];
                    drv_eob  <= drv_frame.eob;
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 16);
                    burst_left = burst_left - 1;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and result check
    always @(posedge i_clk) begin
        resampled_t want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_out.size() == 0) begin
                    $error("output transaction with no expected result");
                    mismatch_cnt++;
                end else begin
                    want = expected_out.pop_front();
                    for (int c = 0; c < MAX_CHANNELS; c++) begin
                        if (dut_ch[c] !== want.ch[c]) begin
                            $error("out_ch%0d: expected %0d, actual %0d", c,
                                   $signed(want.ch[c]), $signed(dut_ch[c]));
                            mismatch_cnt++;
                        end
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last, o_last_of_run);
                        mismatch_cnt++;
                    end
                end
            end
            if (pat_age == 0) begin
                pat_age = $urandom_range(20, 120);
                case ($urandom_range(0, 3))
                    0: ready_pat = 16'hFFFF;
                    1: ready_pat = 16'($urandom()) | 16'h0001;
                    2: ready_pat = 16'h0101;
                    default: ready_pat = 16'hEEEE;
                endcase
            end else begin
                pat_age = pat_age - 1;
                ready_pat = {ready_pat[0], ready_pat[15:1]};
            end
            out_ready <= ready_pat[0];
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] st;
        logic [CFG_W-1:0] ch;
        logic [CFG_W-1:0] g;
        int               blk_len;
        int               n_items;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bypass at reset settings
        pending_frames.push_back(uniform_frame(24'h7FFFFF, 1'b0));
        pending_frames.push_back(uniform_frame(24'h800000, 1'b0));
        pending_frames.push_back(uniform_frame(24'h000000, 1'b1));
        pending_frames.push_back(uniform_frame(24'hFFFFFF, 1'b0));
        drain();

        // quarter step, six channels: four per frame, then the frame after the block end silent
        set_config(19'd16384, 19'd6, 19'd32768);
        pending_frames.push_back(uniform_frame(24'h7FFFFF, 1'b0));
        pending_frames.push_back(uniform_frame(24'h800000, 1'b0));
        pending_frames.push_back(uniform_frame(24'h7FFFFF, 1'b0));
        pending_frames.push_back(uniform_frame(24'h000000, 1'b1));
        pending_frames.push_back(uniform_frame(24'h800000, 1'b1));
        drain();

        // max step, channel count above six, gain above unity saturates
        set_config(19'd262144, 19'd7, 19'd65535);
        pending_frames.push_back(uniform_frame(24'h7FFFFF, 1'b0));
        pending_frames.push_back(uniform_frame(24'h800000, 1'b0));
        pending_frames.push_back(uniform_frame(24'hFFFFFF, 1'b0));
        pending_frames.push_back(uniform_frame(24'h7FFFFF, 1'b0));
        pending_frames.push_back(uniform_frame(24'h800000, 1'b1));
        drain();

        // step below range, zero channels, zero gain
        set_config(19'd0, 19'd0, 19'd0);
        pending_frames.push_back(uniform_frame(24'h7FFFFF, 1'b0));
        pending_frames.push_back(uniform_frame(24'h800000, 1'b0));
        pending_frames.push_back(uniform_frame(24'h123456, 1'b1));
        drain();

        // step above range, one channel, half gain
        set_config(19'h7FFFF, 19'd1, 19'd16384);
        for (int i = 0; i < 4; i++)
            pending_frames.push_back(random_frame(i == 3));
        drain();

        set_config(19'd98304, 19'd2, 19'd32767);
        pending_frames.push_back(uniform_frame(24'h7FFFFF, 1'b0));
        pending_frames.push_back(uniform_frame(24'h800000, 1'b0));
        pending_frames.push_back(uniform_frame(24'h7FFFFF, 1'b0));
        pending_frames.push_back(uniform_frame(24'h000001, 1'b1));
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            case ($urandom_range(0, 9))
                0: st = 19'd16384;
                1: st = 19'd65536;
                2: st = 19'd262144;
                3: st = CFG_W'($urandom_range(0, 16383));
                4: st = CFG_W'($urandom_range(262145, 524287));
                5: st = ($urandom_range(0, 1) == 0) ? 19'd65535 : 19'd65537;
                6: st = CFG_W'($urandom_range(16384, 262144));
                default: st = CFG_W'($urandom_range(16384, 131072));
            endcase
            case ($urandom_range(0, 5))
                0, 1: ch = 19'd2;
                2, 3: ch = 19'd6;
                default: ch = CFG_W'($urandom_range(0, 7));
            endcase
            case ($urandom_range(0, 5))
                0, 1: g = 19'd32768;
                2: g = CFG_W'($urandom_range(0, 65535));
                3: g = 19'd0;
                default: g = CFG_W'($urandom_range(16384, 40000));
            endcase
            set_config(st, ch, g);
            n_items = 0;
            while (n_items < 28) begin
                blk_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 16);
                for (int i = 0; i < blk_len; i++)
                    pending_frames.push_back(random_frame(i == blk_len - 1));
                n_items += blk_len;
            end
            drain();
        end

        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
